/* hdl/bcc_pkg.sv */
package bcc_pkg;

	// class alphabet and bigram store geometry
	localparam int NCLASS      = 62;
	localparam int CLASS_W     = 6;
	localparam int RAM_ADDR_W  = 2 * CLASS_W;
	localparam int RAM_DEPTH   = 1 << RAM_ADDR_W;
	localparam int ENTRY_W     = 16;
	localparam int BONUS_W     = 15;
	localparam int CONF_W      = 11;
	localparam int SCORE_W     = ENTRY_W + 2;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(NCLASS - 1);
	localparam logic [7:0]         CHAR_QMARK = 8'h3F;

	// register indexes on the config port
	localparam logic [1:0] REG_HIGH  = 2'd0;
	localparam logic [1:0] REG_MID   = 2'd1;
	localparam logic [1:0] REG_BONUS = 2'd2;

	localparam logic [CONF_W-1:0]  HIGH_RST  = CONF_W'(921);
	localparam logic [CONF_W-1:0]  MID_RST   = CONF_W'(512);
	localparam logic [BONUS_W-1:0] BONUS_RST = BONUS_W'(500);

	typedef enum logic [1:0] {
		CMD_CORRECT = 2'd0,
		CMD_PUSH    = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_LOAD    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_PASS    = 2'd0,
		ST_RESCORE = 2'd1,
		ST_INVALID = 2'd2,
		ST_ACK     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CONF_W-1:0]  high_thr;
		logic [CONF_W-1:0]  mid_thr;
		logic [BONUS_W-1:0] bonus;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [CLASS_W-1:0]  class_guess;
		logic [CONF_W-1:0]   confidence;
		logic [7:0]          char_in;
		logic [CLASS_W-1:0]  row;
		logic [CLASS_W-1:0]  column;
		logic [ENTRY_W-1:0]  entry;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic scanning;
	} eng_stat_t;

	// ASCII code of a class index
	function automatic logic [7:0] class_char(input logic [CLASS_W-1:0] c);
		logic [7:0] c8;
		c8 = {2'b00, c};
		if (c < CLASS_W'(10))
			class_char = 8'h30 + c8;
		else if (c < CLASS_W'(36))
			class_char = 8'h41 + c8 - 8'd10;
		else
			class_char = 8'h61 + c8 - 8'd36;
	endfunction

	// class of an alphanumeric ASCII code; ok is low for anything else
	function automatic logic [CLASS_W:0] class_of(input logic [7:0] ch);
		logic [7:0] k;
		logic       ok;
		ok = 1'b1;
		k  = 8'd0;
		if (ch >= 8'h30 && ch <= 8'h39)
			k = ch - 8'h30;
		else if (ch >= 8'h41 && ch <= 8'h5A)
			k = ch - 8'h41 + 8'd10;
		else if (ch >= 8'h61 && ch <= 8'h7A)
			k = ch - 8'h61 + 8'd36;
		else
			ok = 1'b0;
		class_of = {ok, k[CLASS_W-1:0]};
	endfunction

endpackage

/* hdl/bcc_ram.sv */
module bcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/bcc_regs.sv */
module bcc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bcc_pkg::PADDR_W-1:0]   paddr,
	input  logic [bcc_pkg::PDATA_W-1:0]   pwdata,
	output logic [bcc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output bcc_pkg::cfg_t                 cfg
);
	import bcc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr <= HIGH_RST;
			cfg_q.mid_thr  <= MID_RST;
			cfg_q.bonus    <= BONUS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HIGH:  cfg_q.high_thr <= pwdata[CONF_W-1:0];
				REG_MID:   cfg_q.mid_thr  <= pwdata[CONF_W-1:0];
				REG_BONUS: cfg_q.bonus    <= pwdata[BONUS_W-1:0];
				default:   ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_HIGH:  prdata = PDATA_W'(cfg_q.high_thr);
			REG_MID:   prdata = PDATA_W'(cfg_q.mid_thr);
			REG_BONUS: prdata = PDATA_W'(cfg_q.bonus);
			default:   prdata = '0;
		endcase
	end

endmodule

/* hdl/bcc_engine.sv */
module bcc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  bcc_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  bcc_pkg::item_t      item,
	input  logic                out_free,
	output logic                res_valid,
	output logic [7:0]          res_char,
	output logic [1:0]          res_status,
	output bcc_pkg::eng_stat_t  stat
);
	import bcc_pkg::*;

	state_t state_q, state_d;

	logic [RAM_ADDR_W-1:0] clr_cnt_q;
	logic [CLASS_W-1:0]    last_q;
	logic                  ctx_q;
	logic [CLASS_W-1:0]    row_q;
	logic [CLASS_W-1:0]    guess_q;
	logic [BONUS_W-1:0]    bonus_q;
	logic [CLASS_W-1:0]    rd_cnt_q;
	logic                  vld_s1;
	logic [CLASS_W-1:0]    col_s1;
	logic signed [SCORE_W-1:0] best_q;
	logic [CLASS_W-1:0]    win_col_q;

	logic                  guess_bad;
	logic                  pass;
	logic                  need_scan;
	logic                  accept;
	logic [CLASS_W:0]      push_cls;

	logic                  ram_we;
	logic [RAM_ADDR_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic                  ram_re;
	logic [ENTRY_W-1:0]    ram_rdata;

	logic signed [SCORE_W-1:0] score;
	logic                      take;

	// decode of the offered word
	assign guess_bad = item.class_guess > LAST_CLASS;
	assign pass      = (item.confidence > cfg.high_thr) || (item.confidence <= cfg.mid_thr)
		|| !ctx_q;
	assign need_scan = (item.cmd == CMD_CORRECT) && !guess_bad && !pass;
	assign push_cls  = class_of(item.char_in);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (&clr_cnt_q) state_d = S_IDLE;
			S_IDLE:   if (in_valid && need_scan) state_d = S_SCAN;
			S_SCAN:   if (rd_cnt_q == LAST_CLASS) state_d = S_FINISH;
			S_FINISH: state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		res_char   = 8'd0;
		res_status = ST_ACK;
		ram_we     = 1'b0;
		ram_waddr  = {item.row, item.column};
		ram_wdata  = item.entry;
		ram_re     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				in_ready  = out_free || need_scan;
				res_valid = in_valid && in_ready && !need_scan;
				if (item.cmd == CMD_CORRECT) begin
					if (guess_bad) begin
						res_char   = CHAR_QMARK;
						res_status = ST_INVALID;
					end else begin
						res_char   = class_char(item.class_guess);
						res_status = ST_PASS;
					end
				end
				ram_we = in_valid && in_ready && (item.cmd == CMD_LOAD)
					&& (item.row <= LAST_CLASS) && (item.column <= LAST_CLASS);
			end
			S_SCAN: begin
				ram_re = 1'b1;
			end
			S_DONE: begin
				res_valid  = out_free;
				res_char   = class_char(win_col_q);
				res_status = ST_RESCORE;
			end
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	assign stat.clearing = (state_q == S_CLEAR);
	assign stat.scanning = (state_q == S_SCAN) || (state_q == S_FINISH) || (state_q == S_DONE);

	bcc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({row_q, rd_cnt_q}),
		.rdata (ram_rdata)
	);

	// score of the column whose entry just came back
	assign score = SCORE_W'(signed'(ram_rdata))
		+ ((col_s1 == guess_q) ? signed'({3'b000, bonus_q}) : SCORE_W'(0));
	assign take  = (col_s1 == '0) || (score > best_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			last_q    <= '0;
			ctx_q     <= 1'b0;
			rd_cnt_q  <= '0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			// context updates
			if (state_q == S_IDLE && accept) begin
				if (item.cmd == CMD_PUSH && push_cls[CLASS_W]) begin
					last_q <= push_cls[CLASS_W-1:0];
					ctx_q  <= 1'b1;
				end else if (item.cmd == CMD_CLEAR) begin
					ctx_q <= 1'b0;
				end
			end
			// row read counter
			if (state_q == S_IDLE) begin
				rd_cnt_q <= '0;
			end else if (state_q == S_SCAN) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			vld_s1 <= (state_q == S_SCAN);
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && need_scan) begin
			row_q   <= last_q;
			guess_q <= item.class_guess;
			bonus_q <= cfg.bonus;
		end
		col_s1 <= rd_cnt_q;
		if (vld_s1 && take) begin
			best_q    <= score;
			win_col_q <= col_s1;
		end
	end

endmodule

/* hdl/bigram_char_corrector.sv */
// Bigram character corrector. Commands push context (1), clear context (2) and
// load a 62x62 bigram table entry (3) are answered with one acknowledge word
// (status 3, char_out 0) in the cycle after acceptance. A correct command (0)
// with an invalid class or a pass-through decision is answered with the same
// timing, carrying '?' with status 2 or the guessed character with status 0;
// these words are taken one per cycle while the output register can drain.
// A correct command that needs rescoring reads the previous class's table row
// from the single store memory, one entry per cycle: after the accepting cycle
// come 62 reads (S_SCAN), the last entry's data and compare (S_FINISH) and the
// handoff to the output register (S_DONE), which waits while the output stalls;
// only then is the next input word taken.
// After reset the block sweeps the 4096-word store to zero, one word per cycle,
// and takes no input word until the sweep ends; register writes are taken
// throughout.
module bigram_char_corrector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bcc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bcc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bcc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [5:0]                   class_guess,
	input  logic [10:0]                  confidence,
	input  logic [7:0]                   char_in,
	input  logic [5:0]                   row,
	input  logic [5:0]                   column,
	input  logic signed [15:0]           entry,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   char_out,
	output logic [1:0]                   status
);
	import bcc_pkg::*;

	cfg_t      cfg;
	item_t     item;
	eng_stat_t stat;
	logic      out_free;
	logic      res_valid;
	logic [7:0] res_char;
	logic [1:0] res_status;
	logic      out_valid_q;
	logic [7:0] char_q;
	logic [1:0] status_q;

	bcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item.cmd         = cmd;
	assign item.class_guess = class_guess;
	assign item.confidence  = confidence;
	assign item.char_in     = char_in;
	assign item.row         = row;
	assign item.column      = column;
	assign item.entry       = entry;

	assign out_free = !out_valid_q || out_ready;

	bcc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.item       (item),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res_char   (res_char),
		.res_status (res_status),
		.stat       (stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			char_q   <= res_char;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign status    = status_q;

	// no input word during the clearing sweep
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ready)
		else $error("input accepted during store clear");

	// non-correct commands are acknowledged in the next cycle
	a_ack_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd != CMD_CORRECT)
		|=> (out_valid && status == ST_ACK && char_out == 8'd0))
		else $error("missing acknowledge word");

	// an invalid guess gives '?' in the next cycle
	a_invalid_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_CORRECT && class_guess > LAST_CLASS)
		|=> (out_valid && status == ST_INVALID && char_out == CHAR_QMARK))
		else $error("invalid class not flagged");

	// a rescored word only comes out of a row scan
	a_rescore_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_RESCORE) |-> stat.scanning)
		else $error("rescored word without a scan");

endmodule
